FILE: design/leg_pkg.sv
// shared widths, constants, coefficient tables and types of the legendre evaluator
package leg_pkg;

  localparam int FracBits  = 14;
  localparam int MaxOrders = 16;
  localparam int MinOrders = 2;
  localparam int CountRst  = 9;

  localparam int XW     = 16;
  localparam int PW     = 16;
  localparam int DW     = 22;
  localparam int CountW = 5;
  localparam int OrderW = $clog2(MaxOrders);
  localparam int CoefW  = 16;
  localparam int TW     = 17;
  localparam int UW     = 24;
  localparam int RndW   = 48;

  localparam int OneQ     = 1 << FracBits;
  localparam int HalfQ    = 1 << (FracBits - 1);
  localparam int PolyLim  = OneQ;
  localparam int SlopeLim = (MaxOrders * (MaxOrders - 1) / 2) * OneQ;

  typedef enum logic [1:0] {
    StIdle,
    StEmit,
    StCalc
  } state_e;

  // current row (p1, d1) and the row before it (p2, d2)
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [PW-1:0] p1;
    logic signed [DW-1:0] d1;
    logic signed [PW-1:0] p2;
    logic signed [DW-1:0] d2;
  } row_t;

  typedef struct packed {
    logic load;
    logic calc;
  } cell_ctrl_t;

  // round to nearest, ties toward +inf, then drop the fraction
  function automatic logic signed [RndW-1:0] round_q(input logic signed [RndW-1:0] v);
    return (v + RndW'(HalfQ)) >>> FracBits;
  endfunction

  // (2n-1)/n in q2.14, rounded half up
  function automatic logic [CoefW-1:0] coef_a(input int unsigned n);
    logic [CoefW-1:0] c;
    case (n)
      2:       c = 16'd24576;
      3:       c = 16'd27307;
      4:       c = 16'd28672;
      5:       c = 16'd29491;
      6:       c = 16'd30037;
      7:       c = 16'd30427;
      8:       c = 16'd30720;
      9:       c = 16'd30948;
      10:      c = 16'd31130;
      11:      c = 16'd31279;
      12:      c = 16'd31403;
      13:      c = 16'd31508;
      14:      c = 16'd31598;
      15:      c = 16'd31676;
      default: c = '0;
    endcase
    return c;
  endfunction

  // (n-1)/n in q2.14, rounded half up
  function automatic logic [CoefW-1:0] coef_b(input int unsigned n);
    logic [CoefW-1:0] c;
    case (n)
      2:       c = 16'd8192;
      3:       c = 16'd10923;
      4:       c = 16'd12288;
      5:       c = 16'd13107;
      6:       c = 16'd13653;
      7:       c = 16'd14043;
      8:       c = 16'd14336;
      9:       c = 16'd14564;
      10:      c = 16'd14746;
      11:      c = 16'd14895;
      12:      c = 16'd15019;
      13:      c = 16'd15124;
      14:      c = 16'd15214;
      15:      c = 16'd15292;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: design/leg_cell.sv
// one recurrence cell: builds row n from rows n-1 and n-2 in two steps
module leg_cell import leg_pkg::*; (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  row_t             row_i,
  input  logic [CoefW-1:0] coef_a_i,
  input  logic [CoefW-1:0] coef_b_i,
  output row_t             row_o
);

  localparam int CsW = CoefW + 1;
  localparam int XpW = XW + PW;
  localparam int XdW = XW + DW;
  localparam int AtW = CsW + TW;
  localparam int BpW = CsW + PW;
  localparam int AuW = CsW + UW;
  localparam int BdW = CsW + DW;
  localparam int PsW = PW + 4;
  localparam int DsW = DW + 4;

  localparam logic signed [PsW-1:0] PHi = PsW'(PolyLim);
  localparam logic signed [PsW-1:0] PLo = -PHi;
  localparam logic signed [DsW-1:0] DHi = DsW'(SlopeLim);
  localparam logic signed [DsW-1:0] DLo = -DHi;

  row_t                  in_q;
  row_t                  row_q, row_d;
  logic signed [TW-1:0]  t_q, t_d;
  logic signed [UW-1:0]  u_q, u_d;

  logic signed [XpW-1:0]  xp_prod;
  logic signed [XdW-1:0]  xd_prod;
  logic signed [RndW-1:0] xp_rnd, xd_rnd;

  logic signed [CsW-1:0]  a_s, b_s;
  logic signed [AtW-1:0]  at_prod;
  logic signed [BpW-1:0]  bp_prod;
  logic signed [AuW-1:0]  au_prod;
  logic signed [BdW-1:0]  bd_prod;
  logic signed [RndW-1:0] at_rnd, bp_rnd, au_rnd, bd_rnd;
  logic signed [PsW-1:0]  p_diff;
  logic signed [DsW-1:0]  d_diff;
  logic signed [PW-1:0]   p_new;
  logic signed [DW-1:0]   d_new;

  // first step: x * p1 and p1 + x * d1
  assign xp_prod = row_i.x * row_i.p1;
  assign xd_prod = row_i.x * row_i.d1;
  assign xp_rnd  = round_q(RndW'(xp_prod));
  assign xd_rnd  = round_q(RndW'(xd_prod));
  assign t_d     = $signed(xp_rnd[TW-1:0]);
  assign u_d     = UW'(row_i.p1) + $signed(xd_rnd[UW-1:0]);

  // second step: coefficient products, difference and saturation
  assign a_s     = $signed({1'b0, coef_a_i});
  assign b_s     = $signed({1'b0, coef_b_i});
  assign at_prod = a_s * t_q;
  assign bp_prod = b_s * in_q.p2;
  assign au_prod = a_s * u_q;
  assign bd_prod = b_s * in_q.d2;
  assign at_rnd  = round_q(RndW'(at_prod));
  assign bp_rnd  = round_q(RndW'(bp_prod));
  assign au_rnd  = round_q(RndW'(au_prod));
  assign bd_rnd  = round_q(RndW'(bd_prod));
  assign p_diff  = $signed(at_rnd[PsW-1:0]) - $signed(bp_rnd[PsW-1:0]);
  assign d_diff  = $signed(au_rnd[DsW-1:0]) - $signed(bd_rnd[DsW-1:0]);

  always_comb begin
    if (p_diff > PHi) begin
      p_new = PHi[PW-1:0];
    end else if (p_diff < PLo) begin
      p_new = PLo[PW-1:0];
    end else begin
      p_new = p_diff[PW-1:0];
    end
    if (d_diff > DHi) begin
      d_new = DHi[DW-1:0];
    end else if (d_diff < DLo) begin
      d_new = DLo[DW-1:0];
    end else begin
      d_new = d_diff[DW-1:0];
    end
  end

  always_comb begin
    row_d.x  = in_q.x;
    row_d.p1 = p_new;
    row_d.d1 = d_new;
    row_d.p2 = in_q.p1;
    row_d.d2 = in_q.d1;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      in_q <= row_i;
      t_q  <= t_d;
      u_q  <= u_d;
    end
    if (ctrl_i.calc) begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

FILE: design/legendre_value_and_slope_eval_core.sv
// legendre value and slope evaluator: sequencer, row of recurrence cells, output register
// sequence: order_count clamped to 2..16; the abscissa is taken in the idle state, orders 0 and 1
//   each take one emit state, every later order a calc state and an emit state (x*P, then the
//   coefficient products, registered between); an output stall holds the emit state, and a new
//   abscissa is taken only once the sweep is back in the idle state
// reset: asynchronous, active low; clears control state and sets order_count to 9, no sweep
module legendre_value_and_slope_eval_core import leg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [XW-1:0] x_value_i,
  input  logic                 cfg_we_i,
  input  logic [CountW-1:0]    cfg_wdata_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OrderW-1:0]    order_o,
  output logic signed [PW-1:0] poly_value_o,
  output logic signed [DW-1:0] poly_slope_o,
  output logic                 last_o
);

  localparam logic signed [PW-1:0] PHi = PW'(PolyLim);
  localparam logic signed [PW-1:0] PLo = -PHi;

  state_e               state_q, state_d;
  logic [OrderW-1:0]    n_q, n_d;
  logic [OrderW-1:0]    last_n_q, last_n_d;
  logic signed [XW-1:0] x_q;
  logic [CountW-1:0]    cfg_q;

  logic                 out_valid_q;
  logic [OrderW-1:0]    out_order_q;
  logic signed [PW-1:0] out_poly_q;
  logic signed [DW-1:0] out_slope_q;
  logic                 out_last_q;

  logic                 in_take;
  logic                 out_load;
  logic                 is_last;
  logic signed [PW-1:0] x_sat;

  row_t       cell_row  [MaxOrders];
  cell_ctrl_t cell_ctrl [MaxOrders];

  assign in_take  = in_valid_i && (state_q == StIdle);
  assign is_last  = (n_q == last_n_q);

  // clamp of order_count to the supported span
  always_comb begin
    if (cfg_q < CountW'(MinOrders)) begin
      last_n_d = OrderW'(MinOrders - 1);
    end else if (cfg_q > CountW'(MaxOrders)) begin
      last_n_d = OrderW'(MaxOrders - 1);
    end else begin
      last_n_d = OrderW'(cfg_q - CountW'(1));
    end
  end

  always_comb begin
    if (x_q > PHi) begin
      x_sat = PHi;
    end else if (x_q < PLo) begin
      x_sat = PLo;
    end else begin
      x_sat = x_q;
    end
  end

  // seed rows: order 0 is (1, 0), order 1 is (x, 1)
  always_comb begin
    cell_row[0].x  = x_q;
    cell_row[0].p1 = PW'(OneQ);
    cell_row[0].d1 = '0;
    cell_row[0].p2 = '0;
    cell_row[0].d2 = '0;
    cell_row[1].x  = x_q;
    cell_row[1].p1 = x_sat;
    cell_row[1].d1 = DW'(OneQ);
    cell_row[1].p2 = PW'(OneQ);
    cell_row[1].d2 = '0;
  end

  for (genvar k = 2; k < MaxOrders; k++) begin : g_cell
    leg_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (cell_ctrl[k]),
      .row_i    (cell_row[k-1]),
      .coef_a_i (coef_a(k)),
      .coef_b_i (coef_b(k)),
      .row_o    (cell_row[k])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_load) begin
          if (is_last) begin
            state_d = StIdle;
          end else if (n_q == '0) begin
            state_d = StEmit;
          end else begin
            state_d = StCalc;
          end
        end
      end
      StCalc: begin
        state_d = StEmit;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // sequencer outputs: output load and cell strobes
  always_comb begin
    out_load = (state_q == StEmit) && (!out_valid_q || !out_stall_i);
    n_d      = n_q;
    if (out_load && !is_last) begin
      n_d = n_q + OrderW'(1);
    end
    for (int k = 0; k < MaxOrders; k++) begin
      // first step of the next cell runs while this order leaves
      cell_ctrl[k].load = out_load && !is_last && (n_d == OrderW'(k));
      cell_ctrl[k].calc = (state_q == StCalc) && (n_q == OrderW'(k));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      n_q         <= '0;
      last_n_q    <= '0;
      cfg_q       <= CountW'(CountRst);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (in_take) begin
        n_q      <= '0;
        last_n_q <= last_n_d;
      end else begin
        n_q <= n_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      x_q <= x_value_i;
    end
    if (out_load) begin
      out_order_q <= n_q;
      out_poly_q  <= cell_row[n_q].p1;
      out_slope_q <= cell_row[n_q].d1;
      out_last_q  <= is_last;
    end
  end

  assign in_stall_o   = (state_q != StIdle);
  assign out_valid_o  = out_valid_q;
  assign order_o      = out_order_q;
  assign poly_value_o = out_poly_q;
  assign poly_slope_o = out_slope_q;
  assign last_o       = out_last_q;

endmodule

FILE: design/leg_checker.sv
// port-level checks of the legendre evaluator, bound to the top level
module leg_checker import leg_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [OrderW-1:0]    order_o,
  input logic signed [PW-1:0] poly_value_o,
  input logic signed [DW-1:0] poly_slope_o,
  input logic                 last_o
);

  localparam logic signed [PW-1:0] POne  = PW'(OneQ);
  localparam logic signed [DW-1:0] DOne  = DW'(OneQ);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(order_o) &&
      $stable(poly_value_o) && $stable(poly_slope_o) && $stable(last_o))
    else $error("stalled result changed");

  // orders of one abscissa follow each other without skipped orders
  a_order_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=>
      !out_valid_o || (order_o == OrderW'($past(order_o) + OrderW'(1))))
    else $error("order sequence broken");

  a_seed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (order_o == '0) |-> (poly_value_o == POne) && (poly_slope_o == '0) &&
      !last_o)
    else $error("order zero row wrong");

  a_seed_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (order_o == OrderW'(1)) |-> (poly_slope_o == DOne))
    else $error("order one slope wrong");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (poly_value_o <= POne) && (poly_value_o >= -POne))
    else $error("value outside saturation range");

endmodule

bind legendre_value_and_slope_eval_core leg_checker u_leg_checker (.*);
